### design/bst_pkg.sv
// Shared types and constants for the bounded set table.
package bst_pkg;

  localparam int OP_W       = 2;
  localparam int ITEM_W     = 32;
  localparam int POSITION_W = 8;
  localparam int COUNT_W    = 9;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 2'd0,
    OP_ERASE    = 2'd1,
    OP_CONTAINS = 2'd2,
    OP_GET      = 2'd3
  } bst_op_t;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_APPLY = 1'b1
  } bst_state_t;

  // Per-cycle command broadcast to every cell of the row.
  typedef struct packed {
    logic cmp;
    logic ins;
    logic del;
  } bst_cell_ctl_t;

endpackage

### design/bst_ifs.sv
// Request and result channel interfaces.
interface bst_in_if;
  import bst_pkg::*;
  logic                  valid;
  logic                  ready;
  bst_op_t               op;
  logic [ITEM_W-1:0]     item_value;
  logic [POSITION_W-1:0] position;

  modport source (output valid, output op, output item_value, output position, input ready);
  modport sink   (input valid, input op, input item_value, input position, output ready);
endinterface

interface bst_out_if;
  import bst_pkg::*;
  logic               valid;
  logic               ready;
  logic               ok;
  logic [ITEM_W-1:0]  read_value;
  logic [COUNT_W-1:0] item_count;

  modport source (output valid, output ok, output read_value, output item_count, input ready);
  modport sink   (input valid, input ok, input read_value, input item_count, output ready);
endinterface

### design/bst_cell.sv
// One storage cell of the set row: entry, match flag and shift link.
module bst_cell #(
  parameter int VALUE_WIDTH = 32,
  parameter int CNT_W       = 9,
  parameter int PW          = 9,
  parameter int INDEX       = 0
) (
  input  logic                     clk,
  input  bst_pkg::bst_cell_ctl_t   ctl,
  input  logic [VALUE_WIDTH-1:0]   key,
  input  logic [CNT_W-1:0]         count,
  input  logic [PW-1:0]            pos,
  input  logic [VALUE_WIDTH-1:0]   next_entry,
  input  logic                     shift_in,
  output logic                     shift_out,
  output logic [VALUE_WIDTH-1:0]   entry,
  output logic [VALUE_WIDTH-1:0]   rd_part
);
  import bst_pkg::*;

  logic [VALUE_WIDTH-1:0] entry_r;
  logic                   hit_r;
  logic                   in_use;

  assign in_use    = CNT_W'(INDEX) < count;
  // A hit here or in any earlier cell moves this cell up from its neighbor.
  assign shift_out = shift_in | hit_r;
  assign entry     = entry_r;
  assign rd_part   = (pos == PW'(INDEX)) ? entry_r : '0;

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      hit_r <= in_use && (entry_r == key);
    end
    if (ctl.ins && (count == CNT_W'(INDEX))) begin
      entry_r <= key;
    end else if (ctl.del && shift_out) begin
      entry_r <= next_entry;
    end
  end

endmodule

### design/bounded_set_table.sv
// Top level of the bounded set table: cell row, control and result register.
//
//  channel | dir | handshake         | payload
//  in_ch   | in  | valid/ready       | op, item_value, position
//  out_ch  | out | valid/ready       | ok, read_value, item_count
//
// Each request: the transfer cycle compares the key in every cell; the update
// cycle, once the result register is free, updates the row and loads the result register.
// Erase shifts all later cells down by one in that same update cycle.
// A held result stalls the update cycle; a new request is taken while a
// result waits. Reset clears the count and control; entries are not cleared.
module bounded_set_table #(
  parameter int CAPACITY    = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  bst_in_if.sink     in_ch,
  bst_out_if.source  out_ch
);
  import bst_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int PW    = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;

  bst_state_t             state_r, state_nxt;
  bst_op_t                op_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [POSITION_W-1:0]  pos_r;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic                   out_valid_r;
  logic                   ok_r;
  logic [ITEM_W-1:0]      rd_r;
  logic [COUNT_W-1:0]     cnt_out_r;

  bst_cell_ctl_t          ctl;
  logic                   accept;
  logic                   fire_apply;
  logic                   found;
  logic                   get_ok;
  logic                   res_ok;
  logic [ITEM_W-1:0]      res_rd;
  logic [VALUE_WIDTH-1:0] key;
  logic [VALUE_WIDTH-1:0] rd_any;
  logic [PW-1:0]          pos_ext;

  logic [CAPACITY:0]      shift;
  logic [VALUE_WIDTH-1:0] entry   [CAPACITY];
  logic [VALUE_WIDTH-1:0] rd_part [CAPACITY];

  assign accept     = in_ch.valid && in_ch.ready;
  assign fire_apply = (state_r == S_APPLY) && (!out_valid_r || out_ch.ready);
  assign key        = (state_r == S_IDLE) ? VALUE_WIDTH'(in_ch.item_value) : val_r;
  assign pos_ext    = PW'(pos_r);
  assign get_ok     = pos_ext < PW'(count_r);
  assign shift[0]   = 1'b0;
  assign found      = shift[CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    bst_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .CNT_W       (CNT_W),
      .PW          (PW),
      .INDEX       (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .key        (key),
      .count      (count_r),
      .pos        (pos_ext),
      .next_entry ((i == CAPACITY - 1) ? entry[i] : entry[(i + 1) % CAPACITY]),
      .shift_in   (shift[i]),
      .shift_out  (shift[i+1]),
      .entry      (entry[i]),
      .rd_part    (rd_part[i])
    );
  end

  // Only the addressed cell drives a nonzero word.
  always_comb begin
    rd_any = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_any = rd_any | rd_part[i];
    end
  end

  always_comb begin
    ctl       = '0;
    state_nxt = state_r;
    count_nxt = count_r;
    res_ok    = 1'b0;
    res_rd    = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          ctl.cmp   = 1'b1;
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        if (fire_apply) begin
          state_nxt = S_IDLE;
          unique case (op_r)
            OP_INSERT: begin
              if ((count_r < CNT_W'(CAPACITY)) && !found) begin
                ctl.ins   = 1'b1;
                count_nxt = count_r + 1'b1;
                res_ok    = 1'b1;
              end
            end
            OP_ERASE: begin
              if (found) begin
                ctl.del   = 1'b1;
                count_nxt = count_r - 1'b1;
                res_ok    = 1'b1;
              end
            end
            OP_CONTAINS: begin
              res_ok = found;
            end
            OP_GET: begin
              if (get_ok) begin
                res_ok = 1'b1;
                res_rd = ITEM_W'(rd_any);
              end
            end
          endcase
        end
      end
    endcase
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.ok         = ok_r;
  assign out_ch.read_value = rd_r;
  assign out_ch.item_count = cnt_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (fire_apply) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_ch.op;
      val_r <= VALUE_WIDTH'(in_ch.item_value);
      pos_r <= in_ch.position;
    end
    if (fire_apply) begin
      ok_r      <= res_ok;
      rd_r      <= res_rd;
      cnt_out_r <= COUNT_W'(count_nxt);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("stored count above capacity");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    fire_apply |=> out_valid_r)
    else $error("update cycle did not present a result");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (fire_apply && (op_r == OP_INSERT) && res_ok) |=>
      (count_r == CNT_W'($past(count_r) + 1'b1)))
    else $error("successful insert did not grow the count");

  a_lookup_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (fire_apply && ((op_r == OP_CONTAINS) || (op_r == OP_GET))) |=>
      (count_r == $past(count_r)))
    else $error("lookup changed the count");

endmodule

### bench/tb_bounded_set_table.sv
// Self-checking testbench for the bounded set table: directed and random traffic, scoreboard, stalls.
module tb_bounded_set_table;
  import bst_pkg::*;

  localparam int CAPACITY   = 256;
  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD  = 300;

  typedef struct packed {
    bst_op_t               op;
    logic [ITEM_W-1:0]     value;
    logic [POSITION_W-1:0] pos;
  } set_req_t;

  typedef struct packed {
    logic               ok;
    logic [ITEM_W-1:0]  read_value;
    logic [COUNT_W-1:0] item_count;
  } set_reply_t;

  logic clk;
  logic rst_n;

  bst_in_if  in_ch ();
  bst_out_if out_ch ();

  bounded_set_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predicted contents of the table.
  logic [ITEM_W-1:0] model_entries [CAPACITY];
  int                model_count;

  // Members as seen by the request generator, used to aim hits and misses.
  logic [ITEM_W-1:0] shadow_members [$];

  set_req_t   request_q [$];
  set_reply_t pending_reply_q [$];
  set_req_t   cur_req;
  set_reply_t got_reply;

  int request_total;
  int accepted_count;
  int fail_count;
  int idle_cycles;
  int send_wait;
  int send_calm;
  int hold_left;
  int recv_calm;
  int replies_seen;
  bit long_hold_done;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic set_reply_t predict_reply(set_req_t r);
    set_reply_t res;
    int         hit;
    res = '0;
    hit = model_count;
    for (int k = 0; k < model_count; k++)
      if (model_entries[k] == r.value && hit == model_count) hit = k;
    case (r.op)
      OP_INSERT: begin
        if (model_count < CAPACITY && hit == model_count) begin
          model_entries[model_count] = r.value;
          model_count++;
          res.ok = 1'b1;
        end
      end
      OP_ERASE: begin
        if (hit < model_count) begin
          // shift later entries down to close the hole
          for (int k = hit; k + 1 < model_count; k++)
            model_entries[k] = model_entries[k + 1];
          model_count--;
          res.ok = 1'b1;
        end
      end
      OP_CONTAINS: res.ok = (hit < model_count);
      default: begin
        if (int'(r.pos) < model_count) begin
          res.read_value = model_entries[r.pos];
          res.ok = 1'b1;
        end
      end
    endcase
    res.item_count = COUNT_W'(model_count);
    return res;
  endfunction

  function automatic int pause_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(30, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic queue_request(bst_op_t op, logic [ITEM_W-1:0] v, logic [POSITION_W-1:0] p);
    int idx;
    idx = -1;
    for (int k = 0; k < shadow_members.size(); k++)
      if (shadow_members[k] == v && idx < 0) idx = k;
    if (op == OP_INSERT && idx < 0 && shadow_members.size() < CAPACITY)
      shadow_members.push_back(v);
    if (op == OP_ERASE && idx >= 0) shadow_members.delete(idx);
    request_q.push_back('{op: op, value: v, pos: p});
  endtask

  task automatic queue_random(int w_ins, int w_era, int w_con);
    bst_op_t               op;
    logic [ITEM_W-1:0]     v;
    logic [POSITION_W-1:0] p;
    int                    r;
    int                    n;
    int                    hit_pct;
    r = $urandom_range(0, 99);
    n = shadow_members.size();
    if (r < w_ins) begin
      op = OP_INSERT;
      hit_pct = 15;
    end else if (r < w_ins + w_era) begin
      op = OP_ERASE;
      hit_pct = 75;
    end else if (r < w_ins + w_era + w_con) begin
      op = OP_CONTAINS;
      hit_pct = 50;
    end else begin
      op = OP_GET;
      hit_pct = 50;
    end
    // small values collide often after erase and reinsert
    v = ($urandom_range(0, 4) == 0) ? ITEM_W'($urandom_range(0, 15)) : ITEM_W'($urandom);
    if (n > 0 && $urandom_range(0, 99) < hit_pct) v = shadow_members[$urandom_range(0, n - 1)];
    p = POSITION_W'($urandom_range(0, 255));
    if (op == OP_GET && n > 0 && $urandom_range(0, 99) < 60)
      p = POSITION_W'($urandom_range(0, n - 1));
    queue_request(op, v, p);
  endtask

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.op        = OP_INSERT;
    in_ch.item_value = '0;
    in_ch.position  = '0;
    out_ch.ready    = 1'b0;
    model_count     = 0;
    accepted_count  = 0;
    fail_count      = 0;

    // Directed: empty table, extremes, duplicates, shifts on erase, range edges.
    queue_request(OP_GET, 32'hDEAD_BEEF, 8'd0);
    queue_request(OP_ERASE, 32'd5, 8'hFF);
    queue_request(OP_CONTAINS, 32'd0, 8'h00);
    queue_request(OP_INSERT, 32'h0000_0000, 8'hFF);
    queue_request(OP_INSERT, 32'hFFFF_FFFF, 8'h00);
    queue_request(OP_INSERT, 32'h0000_0000, 8'h55);
    queue_request(OP_INSERT, 32'h5A5A_5A5A, 8'hAA);
    queue_request(OP_INSERT, 32'hA5A5_A5A5, 8'h00);
    queue_request(OP_CONTAINS, 32'hFFFF_FFFF, 8'hFF);
    queue_request(OP_CONTAINS, 32'h1234_5678, 8'h00);
    queue_request(OP_GET, 32'hFFFF_FFFF, 8'd0);
    queue_request(OP_GET, 32'h0000_0000, 8'd3);
    queue_request(OP_GET, 32'h0000_0000, 8'd4);
    queue_request(OP_GET, 32'h0000_0000, 8'd255);
    queue_request(OP_ERASE, 32'hFFFF_FFFF, 8'h00);
    queue_request(OP_GET, 32'h0000_0000, 8'd1);
    queue_request(OP_ERASE, 32'hFFFF_FFFF, 8'h00);
    queue_request(OP_ERASE, 32'hA5A5_A5A5, 8'h00);
    queue_request(OP_ERASE, 32'h0000_0000, 8'h00);
    queue_request(OP_GET, 32'h0000_0000, 8'd0);
    queue_request(OP_CONTAINS, 32'h5A5A_5A5A, 8'h7F);

    // Random: fill to capacity, hammer the full table, churn, drain, then mix.
    while (shadow_members.size() < CAPACITY) queue_random(75, 5, 10);
    repeat (30) queue_random(50, 5, 15);
    repeat (150) queue_random(40, 35, 15);
    while (shadow_members.size() > 0) queue_random(10, 70, 10);
    repeat (120) queue_random(30, 30, 20);
    request_total = request_q.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_count < request_total || pending_reply_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_reply_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Request driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_wait = 0;
      send_calm = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        pending_reply_q.push_back(predict_reply(cur_req));
        accepted_count++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_wait > 0) begin
          send_wait--;
          in_ch.valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          cur_req = request_q.pop_front();
          in_ch.op         <= cur_req.op;
          in_ch.item_value <= cur_req.value;
          in_ch.position   <= cur_req.pos;
          in_ch.valid      <= 1'b1;
          send_wait = pause_len(send_calm);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: random back-pressure plus one long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left = 0;
      recv_calm = 0;
      replies_seen = 0;
      long_hold_done = 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) replies_seen++;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!long_hold_done && replies_seen >= 200) begin
        // let the block fill up and stall its input
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        out_ch.ready <= 1'b0;
      end else begin
        hold_left = pause_len(recv_calm);
        if (hold_left > 0) begin
          hold_left--;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_reply_q.size() == 0) begin
        note_failure($sformatf("unexpected result ok=%0b read_value=%h item_count=%0d",
                               out_ch.ok, out_ch.read_value, out_ch.item_count));
      end else begin
        got_reply = pending_reply_q.pop_front();
        if (out_ch.ok !== got_reply.ok || out_ch.read_value !== got_reply.read_value ||
            out_ch.item_count !== got_reply.item_count) begin
          note_failure($sformatf(
            "expected ok=%0b read_value=%h item_count=%0d, got ok=%0b read_value=%h item_count=%0d",
            got_reply.ok, got_reply.read_value, got_reply.item_count,
            out_ch.ok, out_ch.read_value, out_ch.item_count));
        end
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

### files.f
design/bst_pkg.sv
design/bst_ifs.sv
design/bst_cell.sv
design/bounded_set_table.sv
bench/tb_bounded_set_table.sv
